// ===== sv/oblt_pkg.sv =====
// Package for the order book level table: widths, status codes, FSM state type, words.
// No dependencies.
package oblt_pkg;

    localparam int LEVELS_DEF = 64;
    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 48;
    localparam int BPS_W      = 21;
    localparam int CNT_W      = $clog2(LEVELS_DEF + 1);

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_DELETED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4,
        ST_IGNORED  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_BEST_RD,
        S_BEST_CHK,
        S_DIV,
        S_OUT
    } state_t;

    // level update word
    typedef struct packed {
        logic [1:0]         side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } level_word_t;

    // book summary word
    typedef struct packed {
        status_t            status;
        logic [PRICE_W-1:0] bid_top;
        logic [PRICE_W-1:0] ask_top;
        logic [PRICE_W-1:0] spread;
        logic [BPS_W-1:0]   spread_cbp;
        logic [CNT_W-1:0]   bid_level_count;
        logic [CNT_W-1:0]   ask_level_count;
    } book_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic rd_srch;    // read entry at pos
        logic pos_inc;
        logic rd_shift;   // read source entry for shift
        logic wr_shift;   // write shifted entry, advance shift index
        logic wr_new;     // write new/updated entry at pos
        logic fill_inc;
        logic fill_dec;
        logic rd_best;    // read best entries
        logic best_cap;
        logic div_step;
        logic out_load;
        logic shift_init;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic side_ok;
        logic pos_at_end;  // pos == fill
        logic px_lt;       // table px < price
        logic px_eq;
        logic qty_zero;
        logic full;
        logic shift_done;
        logic is_del;      // direction of shift
        logic div_done;
    } sts_t;

endpackage

// ===== sv/oblt_if.sv =====
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface oblt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/oblt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module oblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/oblt_ctrl.sv =====
// Controller FSM for the level table: sequences search, shift, write, best read, divide.
// Depends on oblt_pkg.
module oblt_ctrl import oblt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output ctl_t ctl,
    input  sts_t sts
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ov_next    = ov_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (!sts.side_ok)
                begin
                    state_next = S_BEST_RD;
                end
                else if (sts.pos_at_end)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ctl.rd_srch = 1'b1;
                    state_next  = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (sts.px_lt)
                begin
                    ctl.pos_inc = 1'b1;
                    state_next  = S_SRCH_RD;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctl.shift_init = 1'b1;
                if (sts.px_eq && !sts.pos_at_end)
                begin
                    state_next = sts.qty_zero ? S_SHIFT_RD : S_WRITE;
                end
                else if (sts.qty_zero || sts.full)
                begin
                    state_next = S_BEST_RD;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.shift_done)
                begin
                    if (sts.is_del)
                    begin
                        ctl.fill_dec = 1'b1;
                        state_next   = S_BEST_RD;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    ctl.rd_shift = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.wr_shift = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_WRITE:
            begin
                ctl.wr_new = 1'b1;
                ctl.fill_inc = !(sts.px_eq && !sts.pos_at_end);
                state_next = S_BEST_RD;
            end
            S_BEST_RD:
            begin
                ctl.rd_best = 1'b1;
                state_next  = S_BEST_CHK;
            end
            S_BEST_CHK:
            begin
                ctl.best_cap  = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== sv/oblt_dp.sv =====
// Datapath: two tables in RAM, search index, shift engine, best prices, serial divider.
// Depends on oblt_pkg and oblt_ram.
module oblt_dp import oblt_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    output sts_t                sts,
    input  logic [1:0]          in_side,
    input  logic [PRICE_W-1:0]  in_price,
    input  logic [QTY_W-1:0]    in_quantity,
    output status_t             o_status,
    output logic [PRICE_W-1:0]  o_bid,
    output logic [PRICE_W-1:0]  o_ask,
    output logic [PRICE_W-1:0]  o_spread,
    output logic [BPS_W-1:0]    o_bps,
    output logic [$clog2(LEVELS+1)-1:0] o_bid_cnt,
    output logic [$clog2(LEVELS+1)-1:0] o_ask_cnt
);
    localparam int AW = $clog2(LEVELS);
    localparam int CW = $clog2(LEVELS + 1);
    localparam int EW = PRICE_W + QTY_W;
    // numerator spread*2e6 fits in 53 bits; quotient kept to 21 bits
    localparam int NW = 53;
    localparam int DW = PRICE_W + 1;
    localparam int QSTEPS = NW;
    localparam int SCW = $clog2(QSTEPS + 1);
    localparam logic [20:0] SCALE = 21'd2000000;

    logic [1:0]         side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [CW-1:0]      bfill_reg, afill_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      sh_reg;          // shift index
    logic               del_reg, eq_reg;
    status_t            status_reg, status_next;

    logic is_bid;
    logic [CW-1:0] fill;
    assign is_bid = (side_reg == 2'd0);
    assign fill   = is_bid ? bfill_reg : afill_reg;

    // memories: one per side, entry = {price, quantity}
    logic          b_we, a_we;
    logic [AW-1:0] waddr, raddr, b_raddr, a_raddr;
    logic [EW-1:0] wdata, b_rdata, a_rdata, rdata;

    oblt_ram #(.WIDTH(EW), .DEPTH(LEVELS)) u_bid (
        .clk(clk), .we(b_we), .waddr(waddr), .wdata(wdata),
        .raddr(b_raddr), .rdata(b_rdata));
    oblt_ram #(.WIDTH(EW), .DEPTH(LEVELS)) u_ask (
        .clk(clk), .we(a_we), .waddr(waddr), .wdata(wdata),
        .raddr(a_raddr), .rdata(a_rdata));

    assign rdata = is_bid ? b_rdata : a_rdata;
    logic [PRICE_W-1:0] rpx;
    assign rpx = rdata[EW-1:QTY_W];

    // shift source: delete moves sh+1 -> sh upward; insert moves sh-1 -> sh
    logic [CW-1:0] sh_src;
    assign sh_src = del_reg ? (sh_reg + CW'(1)) : (sh_reg - CW'(1));

    always_comb
    begin
        raddr = pos_reg[AW-1:0];
        if (ctl.rd_shift)
        begin
            raddr = sh_src[AW-1:0];
        end
        b_raddr = raddr;
        a_raddr = raddr;
        if (ctl.rd_best)
        begin
            b_raddr = AW'(bfill_reg - CW'(1));
            a_raddr = '0;
        end
    end

    always_comb
    begin
        waddr = pos_reg[AW-1:0];
        wdata = {price_reg, qty_reg};
        if (ctl.wr_shift)
        begin
            waddr = sh_reg[AW-1:0];
            wdata = rdata;
        end
    end
    assign b_we = (ctl.wr_shift || ctl.wr_new) && is_bid;
    assign a_we = (ctl.wr_shift || ctl.wr_new) && !is_bid;

    assign sts.side_ok    = (side_reg[1] == 1'b0);
    assign sts.pos_at_end = (pos_reg == fill);
    assign sts.px_lt      = (rpx < price_reg);
    assign sts.px_eq      = eq_reg;
    assign sts.qty_zero   = (qty_reg == '0);
    assign sts.full       = (fill >= CW'(LEVELS));
    assign sts.is_del     = del_reg;
    assign sts.shift_done = del_reg ? (sh_reg + CW'(1) >= fill) : (sh_reg == pos_reg);

    // best prices and divider
    logic [PRICE_W-1:0] bid_reg, ask_reg, spr_reg;
    logic [NW-1:0]      num_reg;
    logic [DW-1:0]      den_reg;
    logic [DW:0]        rem_reg;
    logic [BPS_W-1:0]   quo_reg;
    logic [SCW-1:0]     dcnt_reg;
    logic               ok_reg;
    logic [PRICE_W+20:0] prod;
    logic [DW:0]        rem_sh;
    logic [PRICE_W-1:0] nb, na;
    logic               both;
    assign nb   = (bfill_reg != '0) ? b_rdata[EW-1:QTY_W] : '0;
    assign na   = (afill_reg != '0) ? a_rdata[EW-1:QTY_W] : '0;
    assign both = (nb != '0) && (na != '0) && (na >= nb);
    assign prod = spr_reg * SCALE;
    assign rem_sh = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign sts.div_done = (dcnt_reg == '0);

    // compare result of the search read, taken while in the check state
    logic eq_now;
    logic rd_d_reg;
    assign eq_now = (rpx == price_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_d_reg <= 1'b0;
        end
        else
        begin
            rd_d_reg <= ctl.rd_srch;
        end
    end

    always_comb
    begin
        status_next = status_reg;
        if (ctl.load)
        begin
            status_next = in_side[1] ? ST_IGNORED : ST_ABSENT;
        end
        else if (ctl.shift_init)
        begin
            if (eq_reg && !sts.pos_at_end)
            begin
                status_next = sts.qty_zero ? ST_DELETED : ST_UPDATED;
            end
            else if (sts.qty_zero)
            begin
                status_next = ST_ABSENT;
            end
            else
            begin
                status_next = sts.full ? ST_FULL : ST_INSERTED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bfill_reg <= '0;
            afill_reg <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            if (ctl.fill_inc)
            begin
                if (is_bid) bfill_reg <= bfill_reg + CW'(1);
                else        afill_reg <= afill_reg + CW'(1);
            end
            if (ctl.fill_dec)
            begin
                if (is_bid) bfill_reg <= bfill_reg - CW'(1);
                else        afill_reg <= afill_reg - CW'(1);
            end
            if (ctl.best_cap)
            begin
                dcnt_reg <= SCW'(QSTEPS + 1);
            end
            else if (ctl.div_step)
            begin
                dcnt_reg <= dcnt_reg - SCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (ctl.load)
        begin
            side_reg  <= in_side;
            price_reg <= in_price;
            qty_reg   <= in_quantity;
            pos_reg   <= '0;
            eq_reg    <= 1'b0;
        end
        if (rd_d_reg)
        begin
            eq_reg <= eq_now;
        end
        if (ctl.pos_inc)
        begin
            pos_reg <= pos_reg + CW'(1);
        end
        if (ctl.shift_init)
        begin
            // delete walks up from pos, insert walks down from fill
            del_reg <= sts.qty_zero;
            sh_reg  <= sts.qty_zero ? pos_reg : fill;
        end
        if (ctl.wr_shift)
        begin
            sh_reg <= del_reg ? (sh_reg + CW'(1)) : (sh_reg - CW'(1));
        end
        if (ctl.best_cap)
        begin
            bid_reg <= nb;
            ask_reg <= na;
            ok_reg  <= both;
            spr_reg <= both ? (na - nb) : '0;
            den_reg <= DW'(na) + DW'(nb);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (ctl.div_step)
        begin
            if (dcnt_reg == SCW'(QSTEPS + 1))
            begin
                num_reg <= NW'(prod);
            end
            else
            begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[BPS_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[BPS_W-2:0], 1'b0};
                end
            end
        end
        if (ctl.out_load)
        begin
            o_status  <= status_reg;
            o_bid     <= bid_reg;
            o_ask     <= ask_reg;
            o_spread  <= spr_reg;
            o_bps     <= ok_reg ? quo_reg : '0;
            o_bid_cnt <= bfill_reg;
            o_ask_cnt <= afill_reg;
        end
    end
endmodule

// ===== sv/order_book_level_table_core.sv =====
// Top level of the order book level table.
// One word in flight: the next word can be accepted from the cycle after its result loads;
// the table walk and the 53-step restoring divider set the pace.
// Reset: fill counts clear, no result pending; table RAM is not cleared. Uses oblt_ctrl, oblt_dp.
module order_book_level_table_core import oblt_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    oblt_if.sink   in_ch,
    oblt_if.source out_ch
);
    ctl_t ctl;
    sts_t sts;

    oblt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .ctl(ctl), .sts(sts));

    oblt_dp #(.LEVELS(LEVELS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .in_side(in_ch.data.side), .in_price(in_ch.data.price),
        .in_quantity(in_ch.data.quantity),
        .o_status(out_ch.data.status), .o_bid(out_ch.data.bid_top),
        .o_ask(out_ch.data.ask_top), .o_spread(out_ch.data.spread),
        .o_bps(out_ch.data.spread_cbp),
        .o_bid_cnt(out_ch.data.bid_level_count),
        .o_ask_cnt(out_ch.data.ask_level_count));
endmodule

// ===== bench/tb_types_pkg.sv =====
// Side codes used by the bench stimulus.
// Depends on nothing.
package tb_types_pkg;

    localparam logic [1:0] SIDE_BID   = 2'd0;
    localparam logic [1:0] SIDE_ASK   = 2'd1;
    localparam logic [1:0] SIDE_BAD_A = 2'd2;
    localparam logic [1:0] SIDE_BAD_B = 2'd3;

endpackage

// ===== bench/book_checker.sv =====
// Watches the update and summary channels, keeps a shadow book and compares summaries.
// Depends on oblt_pkg, tb_types_pkg, oblt_if.
module book_checker import oblt_pkg::*; import tb_types_pkg::*; #(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    oblt_if      upd_ch,
    oblt_if      book_ch,
    output int   fails,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PRICE_W-1:0] shadow_px  [2][LEVELS];
    logic [QTY_W-1:0]   shadow_qty [2][LEVELS];
    int                 shadow_fill [2];
    book_word_t         summary_q [$];

    function automatic status_t apply_level(int s, logic [PRICE_W-1:0] px,
                                            logic [QTY_W-1:0] qty);
        int n;
        int pos;
        n = shadow_fill[s];
        pos = 0;
        while (pos < n && shadow_px[s][pos] < px)
            pos++;
        if (pos < n && shadow_px[s][pos] == px)
        begin
            if (qty == 0)
            begin
                for (int i = pos; i + 1 < n; i++)
                begin
                    shadow_px[s][i]  = shadow_px[s][i+1];
                    shadow_qty[s][i] = shadow_qty[s][i+1];
                end
                shadow_fill[s] = n - 1;
                return ST_DELETED;
            end
            shadow_qty[s][pos] = qty;
            return ST_UPDATED;
        end
        if (qty == 0)
            return ST_ABSENT;
        if (n >= LEVELS)
            return ST_FULL;
        for (int i = n; i > pos; i--)
        begin
            shadow_px[s][i]  = shadow_px[s][i-1];
            shadow_qty[s][i] = shadow_qty[s][i-1];
        end
        shadow_px[s][pos]  = px;
        shadow_qty[s][pos] = qty;
        shadow_fill[s] = n + 1;
        return ST_INSERTED;
    endfunction

    function automatic book_word_t predict_summary(level_word_t w);
        book_word_t r;
        logic [63:0] bid;
        logic [63:0] ask;
        logic [63:0] spr;
        r = '0;
        if (w.side == SIDE_BID)
            r.status = apply_level(0, w.price, w.quantity);
        else if (w.side == SIDE_ASK)
            r.status = apply_level(1, w.price, w.quantity);
        else
            r.status = ST_IGNORED;
        bid = (shadow_fill[0] > 0) ? 64'(shadow_px[0][shadow_fill[0]-1]) : 64'd0;
        ask = (shadow_fill[1] > 0) ? 64'(shadow_px[1][0]) : 64'd0;
        spr = 0;
        r.spread_cbp = '0;
        if (bid > 0 && ask > 0 && ask >= bid)
        begin
            spr = ask - bid;
            r.spread_cbp = BPS_W'((spr * 64'd2000000) / (ask + bid));
        end
        r.bid_top = bid[PRICE_W-1:0];
        r.ask_top = ask[PRICE_W-1:0];
        r.spread  = spr[PRICE_W-1:0];
        r.bid_level_count = CNT_W'(shadow_fill[0]);
        r.ask_level_count = CNT_W'(shadow_fill[1]);
        return r;
    endfunction

    assign pending = summary_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        book_word_t e;
        book_word_t a;
        if (!rst_n)
        begin
            shadow_fill[0] = 0;
            shadow_fill[1] = 0;
            summary_q.delete();
            fails <= 0;
        end
        else
        begin
            if (book_ch.valid && book_ch.ready)
            begin
                a = book_ch.data;
                if (summary_q.size() == 0)
                begin
                    $display("%0t: summary word with none expected: %p", $time, a);
                    fails <= fails + 1;
                end
                else
                begin
                    e = summary_q.pop_front();
                    if (a.status !== e.status ||
                        a.bid_top !== e.bid_top ||
                        a.ask_top !== e.ask_top ||
                        a.spread !== e.spread ||
                        a.spread_cbp !== e.spread_cbp ||
                        a.bid_level_count !== e.bid_level_count ||
                        a.ask_level_count !== e.ask_level_count)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, a);
                        fails <= fails + 1;
                    end
                end
            end
            if (upd_ch.valid && upd_ch.ready)
                summary_q.insert(summary_q.size(), predict_summary(upd_ch.data));
        end
    end
endmodule

// ===== bench/tb.sv =====
// Top of the bench: clock, reset, update stimulus, summary back-pressure and verdict.
// Depends on oblt_pkg, tb_types_pkg, oblt_if, book_checker, order_book_level_table_core.
module tb import oblt_pkg::*, tb_types_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL      = 90;
    localparam int N_RANDOM  = 880;
    localparam int MAX_CYCLE = 3000000;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   cycle;
    bit   hold_req;
    bit   quiet_mode;

    // Price pools per side: more entries than the table holds, so random
    // traffic hits updates, deletes and full tables alike.
    logic [PRICE_W-1:0] px_pool [2][POOL];

    oblt_if #(.T(level_word_t)) upd_ch ();
    oblt_if #(.T(book_word_t))  book_ch ();

    order_book_level_table_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (upd_ch),
        .out_ch (book_ch)
    );

    book_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd_ch  (upd_ch),
        .book_ch (book_ch),
        .fails   (fails),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run-away guard: count cycles and give up far past the slowest legal run.
    initial
    begin
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle > MAX_CYCLE)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [QTY_W-1:0] rand_qty();
        return QTY_W'({$urandom(), $urandom()});
    endfunction

    // Summary side: random stalls, plus a long hold-off on request so the
    // block backs up and stalls the update channel.
    initial
    begin
        int hold_cnt;
        int stall;
        hold_cnt = 0;
        stall = 0;
        book_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_cnt = 3000;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                book_ch.ready <= 1'b0;
            end else if (stall > 0)
            begin
                stall--;
                book_ch.ready <= 1'b0;
            end else
            begin
                book_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Offer one word; return at the falling edge after it was taken. Valid stays
    // high into the next word when there is no gap.
    task automatic send_level(logic [1:0] side, logic [PRICE_W-1:0] px,
                              logic [QTY_W-1:0] qty);
        int gap;
        level_word_t w;
        gap = pick_gap();
        if (gap > 0)
        begin
            upd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        w.side = side;
        w.price = px;
        w.quantity = qty;
        upd_ch.valid <= 1'b1;
        upd_ch.data <= w;
        do @(posedge clk); while (!upd_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain_book();
        upd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial
    begin
        int r;
        int s;
        upd_ch.valid = 1'b0;
        upd_ch.data = '0;
        hold_req = 1'b0;
        quiet_mode = 1'b0;
        for (int k = 0; k < 2; k++)
            for (int i = 0; i < POOL; i++)
                px_pool[k][i] = $urandom();
        px_pool[0][0] = '1;
        px_pool[0][1] = 32'd1;
        px_pool[1][0] = '1;
        px_pool[1][1] = 32'd1;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty book, ignored sides, absent delete, extremes, crossed book.
        send_level(SIDE_BID, 32'd100, '0);
        send_level(SIDE_BAD_A, 32'd5, 48'd7);
        send_level(SIDE_BAD_B, '1, '1);
        send_level(SIDE_BID, 32'd10000, 48'd1);
        send_level(SIDE_ASK, 32'd10001, '1);
        send_level(SIDE_BID, 32'd10000, 48'd500);
        send_level(SIDE_ASK, '1, 48'd3);
        send_level(SIDE_BID, 32'd1, 48'd3);
        send_level(SIDE_ASK, 32'd10001, '0);
        send_level(SIDE_BID, 32'd10000, '0);
        send_level(SIDE_ASK, 32'd0, 48'd9);
        send_level(SIDE_ASK, 32'd0, '0);
        send_level(SIDE_ASK, 32'd2, 48'd9);
        send_level(SIDE_BID, 32'd50, 48'd9);
        send_level(SIDE_BID, 32'hFFFF_FFFE, 48'd9);
        send_level(SIDE_ASK, '1, '0);
        send_level(SIDE_BID, 32'd50, 48'hAAAA_AAAA_AAAA);
        send_level(SIDE_BID, 32'd7, '0);
        drain_book();

        // Fill the bid side past capacity to reach the full-table case.
        quiet_mode = 1'b1;
        for (int i = 0; i < 70; i++)
            send_level(SIDE_BID, px_pool[0][i], rand_qty());
        quiet_mode = 1'b0;
        drain_book();

        // Random traffic over the pools; long back-pressure once midway.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 60 == 0)
                quiet_mode = ($urandom_range(0, 3) == 0);
            if (n == 300)
                hold_req = 1'b1;
            if (n == 600)
                drain_book();
            r = $urandom_range(0, 99);
            if (r < 4)
                send_level($urandom_range(0, 1) ? SIDE_BAD_A : SIDE_BAD_B,
                           $urandom(), rand_qty());
            else
            begin
                s = $urandom_range(0, 1);
                send_level(s ? SIDE_ASK : SIDE_BID,
                           r < 8 ? $urandom() : px_pool[s][$urandom_range(0, POOL - 1)],
                           r < 40 ? '0 : rand_qty());
            end
        end
        drain_book();
        repeat (400) @(negedge clk);
        if (fails == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ===== order_book_level_table_core.f =====
sv/oblt_pkg.sv
sv/oblt_if.sv
sv/oblt_ram.sv
sv/oblt_ctrl.sv
sv/oblt_dp.sv
sv/order_book_level_table_core.sv
bench/tb_types_pkg.sv
bench/book_checker.sv
bench/tb.sv
